// File: design/indexed_list_of_stacks_assert.svh
// Assertion macros for the indexed list of stacks checker.
// Used by the checker file only.
`ifndef INDEXED_LIST_OF_STACKS_ASSERT_SVH
`define INDEXED_LIST_OF_STACKS_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define ILS_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ILS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

// File: design/ils_pkg.sv
// Package for the indexed list of stacks: constants, status codes, FSM state and
// the controller/datapath command and status structs. No dependencies.
package ils_pkg;
	localparam int MAX_STACKS_DEF = 16;
	localparam int POOL_DEPTH_DEF = 128;
	localparam int VALUE_BITS_DEF = 32;
	localparam int IDX_W = 8;
	localparam int OUT_W = 32;
	localparam int CNT_OUT_W = 5;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_LINK_RD,
		S_LINK_WAIT,
		S_PUSH_WR,
		S_POP_RD,
		S_POP_WAIT,
		S_POP_WR,
		S_SHIFT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;       // capture request
		logic decide;     // classify request, pick table slot
		logic link_rd;    // read free-list link at free_head
		logic push_wr;    // allocate node, write value/link, update table
		logic pop_rd;     // read node at top of indexed stack
		logic pop_wr;     // free node, update table
		logic shift;      // move one table entry down
		logic shift_done; // finish removal, decrement count
		logic set_out;    // capture result
	} ctl_t;

	typedef struct packed {
		logic is_pop;
		logic idx_hit;     // index below stack count
		logic table_full;
		logic pool_room;
		logic use_free;    // allocation comes from free list
		logic emptied;     // popped stack becomes empty
		logic shift_last;  // no more entries to move
	} sts_t;
endpackage

// File: design/indexed_list_of_stacks.sv
// Top level of the indexed list of stacks.
// Instantiates ils_ctrl and ils_dp; depends on ils_pkg.
//
// Usage:
//  Request channel (in_valid/in_stall): cmd, stack_index, push_value.
//  A transaction is taken when in_valid is high and in_stall low.
//  Result channel (out_valid/out_stall): top_value, status, stacks_in_use.
//  Exactly one result per request, in order.
//  Each request is classified in decide; an error case then writes its result,
//  a push reads the free-list link first when it reuses a freed node, and a
//  pop reads and frees the top node, then, if that empties its stack, moves
//  each later table entry down: the worst case. One request is worked on at
//  a time; the next is taken in the cycle after the result is written.
//  The result sits in an output register; the next request is taken while it
//  waits, and only the final write of a later result waits for out_stall.
//  Reset empties the table and the pool allocators; no clearing pass, the
//  pool memories are written before being read.
module indexed_list_of_stacks #(
	parameter int MAX_STACKS = ils_pkg::MAX_STACKS_DEF,
	parameter int POOL_DEPTH = ils_pkg::POOL_DEPTH_DEF,
	parameter int VALUE_BITS = ils_pkg::VALUE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      cmd,
	input  logic [ils_pkg::IDX_W-1:0] stack_index,
	input  logic signed [31:0]        push_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [31:0]        top_value,
	output logic [1:0]                status,
	output logic [4:0]                stacks_in_use
);
	import ils_pkg::*;

	ctl_t ctl;
	sts_t sts;

	ils_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .ctl
	);

	ils_dp #(
		.MAX_STACKS(MAX_STACKS), .POOL_DEPTH(POOL_DEPTH), .VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk, .arst_n, .ctl, .sts, .cmd, .stack_index, .push_value,
		.top_value, .status, .stacks_in_use
	);
endmodule

// File: design/ils_ctrl.sv
// Controller FSM for the indexed list of stacks.
// Depends on ils_pkg.
module ils_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  ils_pkg::sts_t sts,
	output ils_pkg::ctl_t ctl
);
	import ils_pkg::*;

	state_t state_q, state_d;
	logic   busy_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_out_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.set_out)
				busy_out_q <= 1'b1;
			else if (busy_out_q && !out_stall)
				busy_out_q <= 1'b0;
		end
	end

	assign out_valid = busy_out_q;
	// Can take a new request while a result waits; only S_OUT needs the slot free.
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_DECIDE;
			S_DECIDE: begin
				if (sts.is_pop)
					state_d = sts.idx_hit ? S_POP_RD : S_OUT;
				else if ((!sts.idx_hit && sts.table_full) || !sts.pool_room)
					state_d = S_OUT;
				else
					state_d = sts.use_free ? S_LINK_RD : S_PUSH_WR;
			end
			S_LINK_RD:   state_d = S_LINK_WAIT;
			S_LINK_WAIT: state_d = S_PUSH_WR;
			S_PUSH_WR:   state_d = S_OUT;
			S_POP_RD:    state_d = S_POP_WAIT;
			S_POP_WAIT:  state_d = S_POP_WR;
			S_POP_WR:    state_d = sts.emptied ? S_SHIFT : S_OUT;
			S_SHIFT:     state_d = sts.shift_last ? S_OUT : S_SHIFT;
			S_OUT:       if (!busy_out_q || !out_stall) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_IDLE:    ctl.load = in_valid;
			S_DECIDE:  ctl.decide = 1'b1;
			S_LINK_RD: ctl.link_rd = 1'b1;
			S_PUSH_WR: ctl.push_wr = 1'b1;
			S_POP_RD:  ctl.pop_rd = 1'b1;
			S_POP_WR:  ctl.pop_wr = 1'b1;
			S_SHIFT: begin
				ctl.shift = !sts.shift_last;
				ctl.shift_done = sts.shift_last;
			end
			S_OUT: ctl.set_out = !busy_out_q || !out_stall;
			default: ctl.load = 1'b0;
		endcase
	end

	// Error code and table slot are latched in the datapath on decide.
endmodule

// File: design/ils_dp.sv
// Datapath for the indexed list of stacks: node pool memories, stack table,
// allocator registers and result register. Depends on ils_pkg.
module ils_dp #(
	parameter int MAX_STACKS = ils_pkg::MAX_STACKS_DEF,
	parameter int POOL_DEPTH = ils_pkg::POOL_DEPTH_DEF,
	parameter int VALUE_BITS = ils_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ils_pkg::ctl_t               ctl,
	output ils_pkg::sts_t               sts,
	input  logic                        cmd,
	input  logic [ils_pkg::IDX_W-1:0]   stack_index,
	input  logic signed [31:0]          push_value,
	output logic signed [31:0]          top_value,
	output logic [1:0]                  status,
	output logic [4:0]                  stacks_in_use
);
	import ils_pkg::*;

	localparam int PW = $clog2(POOL_DEPTH);
	localparam int FW = $clog2(POOL_DEPTH + 1);
	localparam int SW = $clog2(MAX_STACKS);
	localparam int CW = $clog2(MAX_STACKS + 1);
	localparam int DW = PW + 1;

	logic [VALUE_BITS-1:0] node_value [POOL_DEPTH];
	logic [FW-1:0]         node_link  [POOL_DEPTH];
	logic [FW-1:0]         stack_top_q   [MAX_STACKS];
	logic [DW-1:0]         stack_depth_q [MAX_STACKS];

	logic [FW-1:0] free_head_q, bump_next_q, link_rd_q;
	logic [VALUE_BITS-1:0] val_rd_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] j_q, slot_q;
	logic          cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [PW-1:0] node_q;
	logic [1:0]    code_q;
	logic [VALUE_BITS-1:0] res_val_q;
	logic [1:0]    res_st_q;
	logic [4:0]    res_cnt_q;

	logic hit, from_free;
	logic [FW-1:0] new_node;
	logic [PW-1:0] pop_node;

	assign hit = ({{(IDX_W+1-CW){1'b0}}, count_q} > {1'b0, idx_q});
	assign from_free = (free_head_q < FW'(POOL_DEPTH));
	assign new_node = from_free ? free_head_q : bump_next_q;
	assign pop_node = stack_top_q[slot_q][PW-1:0];

	assign sts.is_pop     = cmd_q;
	assign sts.idx_hit    = hit;
	assign sts.table_full = (count_q >= CW'(MAX_STACKS));
	assign sts.pool_room  = from_free || (bump_next_q < FW'(POOL_DEPTH));
	assign sts.use_free   = from_free;
	// Checked before the decrement lands: the last element is going away.
	assign sts.emptied    = (stack_depth_q[slot_q] <= DW'(1));
	assign sts.shift_last = ({1'b0, j_q} + 1'b1 >= (SW+1)'(count_q));

	// Node memories: one write, one read port each, read data registered.
	always_ff @(posedge clk) begin
		if (ctl.push_wr) begin
			node_value[new_node[PW-1:0]] <= val_q;
			node_link[new_node[PW-1:0]] <= hit ? stack_top_q[slot_q] : FW'(POOL_DEPTH);
		end else if (ctl.pop_wr) begin
			node_link[node_q] <= free_head_q;
		end
		if (ctl.link_rd)
			link_rd_q <= node_link[free_head_q[PW-1:0]];
		else if (ctl.pop_rd)
			link_rd_q <= node_link[pop_node];
		if (ctl.pop_rd)
			val_rd_q <= node_value[pop_node];
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd;
			idx_q <= stack_index;
			val_q <= VALUE_BITS'(push_value);
		end
		if (ctl.pop_rd)
			node_q <= pop_node;
		if (ctl.push_wr) begin
			stack_top_q[slot_q] <= new_node;
			stack_depth_q[slot_q] <= hit ? stack_depth_q[slot_q] + 1'b1 : DW'(1);
		end else if (ctl.pop_wr) begin
			stack_top_q[slot_q] <= link_rd_q;
			if (stack_depth_q[slot_q] != '0)
				stack_depth_q[slot_q] <= stack_depth_q[slot_q] - 1'b1;
		end else if (ctl.shift) begin
			stack_top_q[j_q] <= stack_top_q[j_q + 1'b1];
			stack_depth_q[j_q] <= stack_depth_q[j_q + 1'b1];
		end
		if (ctl.set_out) begin
			res_val_q <= (code_q == ST_OK) ? (cmd_q ? val_rd_q : val_q) : '0;
			res_st_q <= code_q;
			res_cnt_q <= 5'(count_q);
		end
	end

	// Pop emptied: j starts at slot; decide happens before pop_wr.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= FW'(POOL_DEPTH);
			bump_next_q <= '0;
			count_q <= '0;
			j_q <= '0;
			slot_q <= '0;
			code_q <= ST_OK;
		end else begin
			if (ctl.load)
				code_q <= ST_OK;
			if (ctl.push_wr) begin
				if (from_free)
					free_head_q <= link_rd_q;
				else
					bump_next_q <= bump_next_q + 1'b1;
				if (!hit)
					count_q <= count_q + 1'b1;
			end
			if (ctl.pop_wr) begin
				free_head_q <= FW'(node_q);
				j_q <= slot_q;
			end
			if (ctl.shift)
				j_q <= j_q + 1'b1;
			if (ctl.shift_done)
				count_q <= count_q - 1'b1;
			// Error classification and slot selection, in the cycle after load.
			if (ctl.decide) begin
				slot_q <= hit ? idx_q[SW-1:0] : count_q[SW-1:0];
				if (cmd_q && !hit)
					code_q <= ST_MISSING;
				else if (!cmd_q && ((!hit && sts.table_full) || !sts.pool_room))
					code_q <= ST_FULL;
			end
		end
	end

	assign top_value = 32'(res_val_q);
	assign status = res_st_q;
	assign stacks_in_use = res_cnt_q;
endmodule

// File: design/ils_checker.sv
// Port-level checker for indexed_list_of_stacks, bound to the top level.
// Uses the assertion macros header.
`include "indexed_list_of_stacks_assert.svh"
module ils_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] top_value,
	input logic [4:0]  stacks_in_use
);
	import ils_pkg::*;

	`ILS_ASSERT_IMPL(a_status_legal, clk, arst_n, out_valid, status <= ST_FULL)
	`ILS_ASSERT_IMPL(a_err_zero, clk, arst_n, out_valid && status != ST_OK, top_value == 32'd0)
	`ILS_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && !in_stall, in_stall)
	`ILS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(top_value) && $stable(stacks_in_use))
endmodule

bind indexed_list_of_stacks ils_checker u_ils_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.status, .top_value, .stacks_in_use
);
